### sv/kscd_pkg.sv
// kscd_pkg: types, codes and decode helpers for the keypad and serial command decoder
// no dependencies; imported by every module of the block
package kscd_pkg;

	localparam int unsigned FRAME_DEPTH_DEF = 10;
	localparam int unsigned MIN_FILL        = 9;

	localparam logic [5:0] PIN_MASK    = 6'h37;
	localparam logic [7:0] NO_BYTE     = 8'h00;
	localparam logic [7:0] FRAME_OPEN  = 8'h7B;
	localparam logic [7:0] FRAME_CLOSE = 8'h7D;
	localparam logic [7:0] DIGIT_ZERO  = 8'h30;

	localparam logic [23:0] NAME_GAM = "GAM";
	localparam logic [23:0] NAME_GAU = "GAU";
	localparam logic [23:0] NAME_GAL = "GAL";
	localparam logic [23:0] NAME_CAU = "CAU";
	localparam logic [23:0] NAME_CAL = "CAL";
	localparam logic [23:0] NAME_STM = "STM";
	localparam logic [23:0] NAME_GTM = "GTM";

	typedef enum logic [2:0] {
		NAV_NONE  = 3'd0,
		NAV_ENTER = 3'd1,
		NAV_UP    = 3'd2,
		NAV_DOWN  = 3'd3,
		NAV_RIGHT = 3'd4,
		NAV_LEFT  = 3'd5
	} nav_t;

	typedef enum logic [3:0] {
		CMD_NONE     = 4'd0,
		CMD_GETMID   = 4'd1,
		CMD_GETUPPER = 4'd2,
		CMD_GETLOWER = 4'd3,
		CMD_SETUPPER = 4'd4,
		CMD_SETLOWER = 4'd5,
		CMD_SETTIME  = 4'd6,
		CMD_GETTIME  = 4'd7,
		CMD_SHORT    = 4'd8
	} cmd_t;

	typedef struct packed {
		logic        letter_hit;
		nav_t        letter_nav;
		cmd_t        command;
		logic [15:0] level;
		logic [7:0]  hours;
		logic [7:0]  minutes;
		logic [7:0]  seconds;
	} frm_res_t;

	function automatic logic [7:0] digit_pair(input logic [7:0] hi, input logic [7:0] lo);
		logic [7:0] dh;
		logic [7:0] dl;
		dh = hi - DIGIT_ZERO;
		dl = lo - DIGIT_ZERO;
		return 8'((dh * 8'd10) + dl);
	endfunction

	function automatic logic [15:0] level_sum(input logic [7:0] d0, input logic [7:0] d1,
		input logic [7:0] d2, input logic [7:0] d3);
		logic [15:0] w0;
		logic [15:0] w1;
		logic [15:0] w2;
		logic [15:0] w3;
		w0 = {8'h00, d0} - {8'h00, DIGIT_ZERO};
		w1 = {8'h00, d1} - {8'h00, DIGIT_ZERO};
		w2 = {8'h00, d2} - {8'h00, DIGIT_ZERO};
		w3 = {8'h00, d3} - {8'h00, DIGIT_ZERO};
		return 16'((w0 * 16'd1000) + (w1 * 16'd100) + (w2 * 16'd10) + w3);
	endfunction

endpackage

### sv/kscd_in_if.sv
// kscd_in_if: input channel, one pin sample and one optional serial byte per request
// no dependencies
interface kscd_in_if;
	logic       valid;
	logic       ready;
	logic [5:0] key_pins;
	logic [7:0] serial_byte;

	modport source (output valid, output key_pins, output serial_byte, input ready);
	modport sink (input valid, input key_pins, input serial_byte, output ready);
endinterface

### sv/kscd_out_if.sv
// kscd_out_if: result channel, navigation event and decoded command per request
// no dependencies
interface kscd_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  nav_event;
	logic [3:0]  command;
	logic [15:0] level_value;
	logic [7:0]  hours_value;
	logic [7:0]  minutes_value;
	logic [7:0]  seconds_value;

	modport source (output valid, output nav_event, output command, output level_value,
		output hours_value, output minutes_value, output seconds_value, input ready);
	modport sink (input valid, input nav_event, input command, input level_value,
		input hours_value, input minutes_value, input seconds_value, output ready);
endinterface

### sv/keypad_and_serial_command_decoder_top.sv
// keypad_and_serial_command_decoder_top: a request passes through the input register, then
// the result register; throughput one request per cycle while the result side is ready
// the input register stalls only when it is full and the result register stalls, so a new
// request is taken while a finished result waits if the input register is empty
// arst_n clears key history, frame state and both valid flags; frame bytes hold no reset
module keypad_and_serial_command_decoder_top #(
	parameter int unsigned FRAME_DEPTH = kscd_pkg::FRAME_DEPTH_DEF
) (
	input logic        clk,
	input logic        arst_n,
	kscd_in_if.sink    sample,
	kscd_out_if.source result
);
	import kscd_pkg::*;

	logic       valid_s1;
	logic [5:0] keys_s1;
	logic [7:0] byte_s1;
	logic [5:0] prev_keys_q;
	logic [5:0] keys_m;
	logic       advance;
	logic       step;
	nav_t       key_nav;
	nav_t       nav;
	frm_res_t   frm;

	logic        out_valid_q;
	nav_t        nav_q;
	cmd_t        cmd_q;
	logic [15:0] level_q;
	logic [7:0]  hours_q;
	logic [7:0]  minutes_q;
	logic [7:0]  seconds_q;

	assign advance      = !out_valid_q || result.ready;
	assign sample.ready = !valid_s1 || advance;
	assign step         = valid_s1 && advance;
	assign keys_m       = keys_s1 & PIN_MASK;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			keys_s1 <= sample.key_pins;
			byte_s1 <= sample.serial_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_keys_q <= '0;
		end else if (step) begin
			prev_keys_q <= keys_m;
		end
	end

	// later pins win, left highest
	always_comb begin
		key_nav = NAV_NONE;
		if (keys_m != prev_keys_q) begin
			if (!keys_m[5]) begin
				key_nav = NAV_LEFT;
			end else if (!keys_m[4]) begin
				key_nav = NAV_RIGHT;
			end else if (!keys_m[2]) begin
				key_nav = NAV_DOWN;
			end else if (!keys_m[1]) begin
				key_nav = NAV_UP;
			end else if (!keys_m[0]) begin
				key_nav = NAV_ENTER;
			end
		end
	end

	kscd_frame #(
		.FRAME_DEPTH(FRAME_DEPTH)
	) u_frame (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.serial_byte(byte_s1),
		.res        (frm)
	);

	assign nav = frm.letter_hit ? frm.letter_nav : key_nav;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			nav_q     <= nav;
			cmd_q     <= frm.command;
			level_q   <= frm.level;
			hours_q   <= frm.hours;
			minutes_q <= frm.minutes;
			seconds_q <= frm.seconds;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.nav_event     = nav_q;
	assign result.command       = cmd_q;
	assign result.level_value   = level_q;
	assign result.hours_value   = hours_q;
	assign result.minutes_value = minutes_q;
	assign result.seconds_value = seconds_q;

endmodule

### sv/kscd_frame.sv
// kscd_frame: serial letter map, frame collector and command decode
// depends on kscd_pkg
module kscd_frame #(
	parameter int unsigned FRAME_DEPTH = kscd_pkg::FRAME_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic [7:0]         serial_byte,
	output kscd_pkg::frm_res_t res
);
	import kscd_pkg::*;

	localparam int unsigned FW = $clog2(FRAME_DEPTH);

	logic          in_frame_q;
	logic [FW-1:0] fill_q;
	logic [7:0]    store_q [FRAME_DEPTH];
	logic          has_byte;
	logic          do_store;
	logic          last_slot;
	logic [23:0]   name;

	assign has_byte  = serial_byte != NO_BYTE;
	assign do_store  = step && has_byte && in_frame_q && serial_byte != FRAME_CLOSE;
	assign last_slot = fill_q == FW'(FRAME_DEPTH - 1);
	assign name      = {store_q[0], store_q[1], store_q[2]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			fill_q     <= '0;
		end else if (step && has_byte) begin
			if (!in_frame_q) begin
				if (serial_byte == FRAME_OPEN) begin
					in_frame_q <= 1'b1;
					fill_q     <= '0;
				end
			end else if (serial_byte == FRAME_CLOSE) begin
				in_frame_q <= 1'b0;
			end else if (last_slot) begin
				in_frame_q <= 1'b0;
				fill_q     <= '0;
			end else begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_store) begin
			store_q[fill_q] <= serial_byte;
		end
	end

	always_comb begin
		res            = '0;
		res.letter_nav = NAV_NONE;
		res.command    = CMD_NONE;
		if (has_byte && !in_frame_q) begin
			res.letter_hit = 1'b1;
			case (serial_byte) inside
				"D", "d": res.letter_nav = NAV_RIGHT;
				"A", "a": res.letter_nav = NAV_LEFT;
				"W", "w": res.letter_nav = NAV_UP;
				"S", "s": res.letter_nav = NAV_DOWN;
				"E", "e": res.letter_nav = NAV_ENTER;
				default:  res.letter_hit = 1'b0;
			endcase
		end
		if (has_byte && in_frame_q && serial_byte == FRAME_CLOSE) begin
			if (fill_q < FW'(MIN_FILL)) begin
				res.command = CMD_SHORT;
			end else begin
				case (name)
					NAME_GAM: res.command = CMD_GETMID;
					NAME_GAU: res.command = CMD_GETUPPER;
					NAME_GAL: res.command = CMD_GETLOWER;
					NAME_CAU: begin
						res.command = CMD_SETUPPER;
						res.level   = level_sum(store_q[5], store_q[6], store_q[7], store_q[8]);
					end
					NAME_CAL: begin
						res.command = CMD_SETLOWER;
						res.level   = level_sum(store_q[5], store_q[6], store_q[7], store_q[8]);
					end
					NAME_STM: begin
						res.command = CMD_SETTIME;
						res.hours   = digit_pair(store_q[3], store_q[4]);
						res.minutes = digit_pair(store_q[5], store_q[6]);
						res.seconds = digit_pair(store_q[7], store_q[8]);
					end
					NAME_GTM: res.command = CMD_GETTIME;
					default:  res.command = CMD_NONE;
				endcase
			end
		end
	end

endmodule

### sv/kscd_checker.sv
// kscd_checker: port-level checks on the decoder top level, with its bind
// depends on kscd_pkg and keypad_and_serial_command_decoder_top
module kscd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  nav_event,
	input logic [3:0]  command,
	input logic [15:0] level_value,
	input logic [7:0]  hours_value,
	input logic [7:0]  minutes_value,
	input logic [7:0]  seconds_value
);
	import kscd_pkg::*;

	// a free result side never blocks a request
	a_ready_flow: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input stalled while result side ready");

	// a new result follows its request through the input register and the result register
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result without request two cycles earlier");

	// level only for set upper and set lower
	a_level_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && level_value != 16'd0 |-> command == CMD_SETUPPER || command == CMD_SETLOWER)
		else $error("level value on wrong command");

	// time fields only for set time
	a_time_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (hours_value != 8'd0 || minutes_value != 8'd0 || seconds_value != 8'd0)
		|-> command == CMD_SETTIME)
		else $error("time fields on wrong command");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(nav_event) && $stable(command)
		&& $stable(level_value))
		else $error("stalled result changed");

endmodule

bind keypad_and_serial_command_decoder_top kscd_checker u_kscd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (sample.valid),
	.in_ready     (sample.ready),
	.out_valid    (result.valid),
	.out_ready    (result.ready),
	.nav_event    (result.nav_event),
	.command      (result.command),
	.level_value  (result.level_value),
	.hours_value  (result.hours_value),
	.minutes_value(result.minutes_value),
	.seconds_value(result.seconds_value)
);

### sim/kscd_result_checker.sv
// kscd_result_checker: watches the request and result channels of the keypad and serial
// command decoder, predicts every result from the accepted requests and compares in order
// depends on kscd_pkg, kscd_in_if and kscd_out_if
module kscd_result_checker #(
	parameter int unsigned FRAME_DEPTH = kscd_pkg::FRAME_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	kscd_in_if          sample,
	kscd_out_if         result,
	output int unsigned mismatches,
	output int unsigned outstanding
);
	timeunit 1ns;
	timeprecision 1ps;
	import kscd_pkg::*;

	typedef struct packed {
		nav_t        nav;
		cmd_t        cmd;
		logic [15:0] level;
		logic [7:0]  hours;
		logic [7:0]  minutes;
		logic [7:0]  seconds;
	} decode_t;

	decode_t     expected_decodes [$];
	logic [5:0]  last_keys;
	logic        framing;
	logic [3:0]  fill;
	logic [7:0]  frame_bytes [FRAME_DEPTH];
	int unsigned error_total = 0;

	function automatic logic [7:0] pair_value(input int pos);
		int unsigned tens;
		int unsigned ones;
		tens = 32'(frame_bytes[pos]) - 32'(DIGIT_ZERO);
		ones = 32'(frame_bytes[pos + 1]) - 32'(DIGIT_ZERO);
		return 8'(tens * 10 + ones);
	endfunction

	function automatic logic [15:0] level_of_frame();
		int unsigned sum;
		int unsigned weight;
		sum    = 0;
		weight = 1000;
		for (int p = 5; p <= 8; p++) begin
			sum    = sum + (32'(frame_bytes[p]) - 32'(DIGIT_ZERO)) * weight;
			weight = weight / 10;
		end
		return 16'(sum);
	endfunction

	// updates key history and frame state, returns the decode for one request
	function automatic decode_t decode_request(input logic [5:0] pins, input logic [7:0] ch);
		decode_t     d;
		logic [5:0]  keys;
		int unsigned idx;
		d    = '0;
		keys = pins & PIN_MASK;
		if (keys != last_keys) begin
			if (!keys[0]) d.nav = NAV_ENTER;
			if (!keys[1]) d.nav = NAV_UP;
			if (!keys[2]) d.nav = NAV_DOWN;
			if (!keys[4]) d.nav = NAV_RIGHT;
			if (!keys[5]) d.nav = NAV_LEFT;
		end
		last_keys = keys;
		if (ch != NO_BYTE) begin
			if (!framing) begin
				case (ch)
					"D", "d": d.nav = NAV_RIGHT;
					"A", "a": d.nav = NAV_LEFT;
					"W", "w": d.nav = NAV_UP;
					"S", "s": d.nav = NAV_DOWN;
					"E", "e": d.nav = NAV_ENTER;
					FRAME_OPEN: begin
						framing = 1'b1;
						fill    = '0;
					end
					default: ;
				endcase
			end else if (ch == FRAME_CLOSE) begin
				framing = 1'b0;
				if (fill < MIN_FILL) begin
					d.cmd = CMD_SHORT;
				end else begin
					case ({frame_bytes[0], frame_bytes[1], frame_bytes[2]})
						NAME_GAM: d.cmd = CMD_GETMID;
						NAME_GAU: d.cmd = CMD_GETUPPER;
						NAME_GAL: d.cmd = CMD_GETLOWER;
						NAME_CAU: begin
							d.cmd   = CMD_SETUPPER;
							d.level = level_of_frame();
						end
						NAME_CAL: begin
							d.cmd   = CMD_SETLOWER;
							d.level = level_of_frame();
						end
						NAME_STM: begin
							d.cmd     = CMD_SETTIME;
							d.hours   = pair_value(3);
							d.minutes = pair_value(5);
							d.seconds = pair_value(7);
						end
						NAME_GTM: d.cmd = CMD_GETTIME;
						default: d.cmd = CMD_NONE;
					endcase
				end
			end else begin
				idx = fill;
				if (idx < FRAME_DEPTH) begin
					frame_bytes[idx] = ch;
					idx++;
				end
				if (idx >= FRAME_DEPTH) begin
					framing = 1'b0;
					fill    = '0;
				end else begin
					fill = 4'(idx);
				end
			end
		end
		return d;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		decode_t want;
		if (!arst_n) begin
			last_keys = '0;
			framing   = 1'b0;
			fill      = '0;
			expected_decodes.delete();
		end else begin
			if (result.valid && result.ready) begin
				if (expected_decodes.size() == 0) begin
					if (error_total < 10)
						$display("%0t: result with no request pending: nav=%0d cmd=%0d", $realtime,
							result.nav_event, result.command);
					error_total++;
				end else begin
					want = expected_decodes.pop_front();
					if (result.nav_event !== want.nav || result.command !== want.cmd ||
						result.level_value !== want.level || result.hours_value !== want.hours ||
						result.minutes_value !== want.minutes ||
						result.seconds_value !== want.seconds) begin
						if (error_total < 10) begin
							$display("%0t: decode mismatch", $realtime);
							$display("  expected nav=%0d cmd=%0d level=%0d h=%0d m=%0d s=%0d",
								want.nav, want.cmd, want.level, want.hours, want.minutes,
								want.seconds);
							$display("  actual   nav=%0d cmd=%0d level=%0d h=%0d m=%0d s=%0d",
								result.nav_event, result.command, result.level_value,
								result.hours_value, result.minutes_value, result.seconds_value);
						end
						error_total++;
					end
				end
			end
			if (sample.valid && sample.ready)
				expected_decodes.push_back(decode_request(sample.key_pins, sample.serial_byte));
		end
		mismatches  <= error_total;
		outstanding <= expected_decodes.size();
	end

endmodule

### sim/keypad_and_serial_command_decoder_top_tb.sv
// keypad_and_serial_command_decoder_top_tb: drives requests and takes results with random
// gaps, a long result hold-off and a directed opening, then gives the verdict
// depends on kscd_pkg, kscd_in_if, kscd_out_if, kscd_result_checker and the block
module keypad_and_serial_command_decoder_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import kscd_pkg::*;

	localparam int unsigned RANDOM_REQUESTS = 800;
	localparam int unsigned HOLD_AT         = 300;
	localparam int unsigned LONG_HOLD       = 150;
	localparam int unsigned DRAIN_CYCLES    = 10;
	localparam int unsigned LIMIT_NS        = 5_000_000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	int unsigned mismatch_count;
	int unsigned pending_count;
	int unsigned requests_sent = 0;
	int unsigned results_taken = 0;
	logic [5:0]  held_keys = 6'h3F;

	kscd_in_if  sample_ch ();
	kscd_out_if result_ch ();

	keypad_and_serial_command_decoder_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_ch),
		.result (result_ch)
	);

	kscd_result_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample      (sample_ch),
		.result      (result_ch),
		.mismatches  (mismatch_count),
		.outstanding (pending_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int unsigned pick_gap(input bit calm);
		int unsigned r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [5:0] step_keys();
		if ($urandom_range(0, 3) == 0) held_keys = 6'($urandom_range(0, 63));
		return held_keys;
	endfunction

	task automatic send_request(input logic [5:0] pins, input logic [7:0] ch);
		int unsigned gap;
		gap = pick_gap((requests_sent / 60) % 4 == 1);
		if (gap != 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_ch.valid       <= 1'b1;
		sample_ch.key_pins    <= pins;
		sample_ch.serial_byte <= ch;
		do @(posedge clk); while (!sample_ch.ready);
		requests_sent++;
	endtask

	task automatic send_frame(input logic [23:0] name, input int unsigned len);
		logic [7:0] ch;
		send_request(step_keys(), FRAME_OPEN);
		for (int unsigned i = 0; i < len; i++) begin
			if ($urandom_range(0, 9) == 0) send_request(step_keys(), NO_BYTE);
			if (i < 3) ch = name[23 - 8 * i -: 8];
			else if ($urandom_range(0, 4) != 0) ch = DIGIT_ZERO + 8'($urandom_range(0, 9));
			else ch = 8'($urandom_range(1, 255));
			send_request(step_keys(), ch);
		end
		send_request(step_keys(), FRAME_CLOSE);
	endtask

	initial begin
		#(LIMIT_NS);
		$display("** keypad_and_serial_command_decoder_top: FAILED **");
		$finish;
	end

	// result side: random stalls plus one long hold-off while requests keep coming
	initial begin
		int unsigned gap;
		result_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (results_taken == HOLD_AT) gap = LONG_HOLD;
			else gap = pick_gap((results_taken / 50) % 4 == 2);
			if (gap != 0) begin
				result_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!result_ch.valid);
			results_taken++;
		end
	end

	initial begin
		logic [7:0]  stm_bytes [11];
		logic [23:0] name;
		int unsigned len;
		int unsigned r;
		string       nav_letters;
		sample_ch.valid       = 1'b0;
		sample_ch.key_pins    = 6'h3F;
		sample_ch.serial_byte = NO_BYTE;
		nav_letters = "WASDEwasde";
		stm_bytes = '{FRAME_OPEN, "S", "T", "M", "9", "9", 8'hFF, 8'h01, "0", "0", FRAME_CLOSE};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// each key alone, all low, then a change on the masked pin only
		send_request(6'h3F, NO_BYTE);
		send_request(6'h3E, NO_BYTE);
		send_request(6'h3D, NO_BYTE);
		send_request(6'h3B, NO_BYTE);
		send_request(6'h2F, NO_BYTE);
		send_request(6'h1F, NO_BYTE);
		send_request(6'h00, NO_BYTE);
		send_request(6'h08, NO_BYTE);
		// letters alone and over a key event
		send_request(6'h08, "w");
		send_request(6'h3F, "A");
		send_request(6'h2F, "s");
		send_request(6'h2F, "D");
		send_request(6'h2F, "e");
		send_request(6'h2F, FRAME_CLOSE);
		send_request(6'h2F, "x");
		// short frame holding an open brace
		send_request(6'h2F, FRAME_OPEN);
		send_request(6'h2F, FRAME_OPEN);
		send_request(6'h2F, FRAME_CLOSE);
		// set time with wrapping digits, key change inside the frame
		foreach (stm_bytes[i])
			send_request((i == 2) ? 6'h1F : 6'h3F, stm_bytes[i]);

		while (requests_sent < RANDOM_REQUESTS + 30) begin
			r = $urandom_range(0, 99);
			if (r < 65) begin
				case ($urandom_range(0, 8))
					0: name = NAME_GAM;
					1: name = NAME_GAU;
					2: name = NAME_GAL;
					3: name = NAME_CAU;
					4: name = NAME_CAL;
					5: name = NAME_STM;
					6: name = NAME_GTM;
					7: name = {8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
						8'($urandom_range(1, 255))};
					default: name = NAME_CAL ^ 24'(1 << $urandom_range(0, 23));
				endcase
				r = $urandom_range(0, 99);
				if (r < 75) len = MIN_FILL;
				else if (r < 90) len = $urandom_range(0, MIN_FILL - 1);
				else len = $urandom_range(FRAME_DEPTH_DEF, FRAME_DEPTH_DEF + 3);
				send_frame(name, len);
			end else begin
				repeat ($urandom_range(1, 4)) begin
					r = $urandom_range(0, 99);
					if (r < 40) send_request(step_keys(), NO_BYTE);
					else if (r < 70)
						send_request(step_keys(), nav_letters[$urandom_range(0, 9)]);
					else send_request(step_keys(), 8'($urandom_range(0, 255)));
				end
			end
		end
		sample_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_count == 0)
			$display("** keypad_and_serial_command_decoder_top: PASSED **");
		else
			$display("** keypad_and_serial_command_decoder_top: FAILED **");
		$finish;
	end

endmodule
